// ----- design/fres_pkg.sv -----
package fres_pkg;

	localparam int ADDR_BITS = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam int SECTOR_LOG2 = 12;
	localparam int MEDIUM_LOG2 = 15;
	localparam int LARGE_LOG2 = 16;
	localparam int SECTOR_BYTES = 1 << SECTOR_LOG2;
	localparam int MEDIUM_BLOCK_BYTES = 1 << MEDIUM_LOG2;
	localparam int LARGE_BLOCK_BYTES = 1 << LARGE_LOG2;

	localparam int FRAME_LEN = 8;
	localparam int STEP_W = $clog2(FRAME_LEN);

	localparam logic [24:0] LEN_MAX = 25'h100_0000;

	localparam logic [7:0] CMD_EWSR = 8'h50;
	localparam logic [7:0] CMD_WRSR = 8'h01;
	localparam logic [7:0] SR_CLEAR = 8'h00;
	localparam logic [7:0] CMD_WREN = 8'h06;
	localparam logic [7:0] CMD_SECTOR = 8'h20;
	localparam logic [7:0] CMD_MEDIUM = 8'h52;
	localparam logic [7:0] CMD_LARGE = 8'hD8;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REJECT  = 2'd1,
		ST_NOTHING = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [23:0] start_addr;
		logic [24:0] length;
		logic        device_busy;
	} in_item_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       has_byte;
		logic       frame_end;
		status_t    status;
		logic       last;
	} out_item_t;

	// work handed from front to back: one plain result or one erase frame set
	typedef struct packed {
		logic        erase;
		status_t     status;
		logic [7:0]  cmd;
		logic [23:0] addr;
	} job_t;

endpackage

// ----- design/fres_front.sv -----
module fres_front #(
	parameter int ADDR_BITS = fres_pkg::ADDR_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fres_pkg::in_item_t  cmd,
	input  logic                q_full,
	output logic                job_push,
	output fres_pkg::job_t      job
);

	localparam int SL = fres_pkg::SECTOR_LOG2;

	logic                 erasing_q;
	logic [ADDR_BITS-1:0] next_addr_q;
	logic [24:0]          bytes_left_q;

	logic [24:0]          len_sat;
	logic [25:0]          span;
	logic [25:0]          rounded;
	logic [23:0]          base24;
	logic [31:0]          base_w;
	logic [31:0]          addr_w;
	logic                 large_ok;
	logic                 medium_ok;
	logic [24:0]          size;
	logic [7:0]           erase_cmd;
	logic                 finish;
	logic [ADDR_BITS-1:0] addr_next;

	assign job_push = push && !q_full;

	// start: round the base down and the span up to whole sectors
	always_comb begin
		len_sat = (cmd.length > fres_pkg::LEN_MAX) ? fres_pkg::LEN_MAX : cmd.length;
		span = {1'b0, len_sat} + 26'(cmd.start_addr[SL-1:0]) - 26'd1;
		rounded = {span[25:SL], {SL{1'b0}}} + 26'(fres_pkg::SECTOR_BYTES);
		base24 = {cmd.start_addr[23:SL], {SL{1'b0}}};
		base_w = 32'(base24);
	end

	// tick: largest aligned erase that fits in what is left
	always_comb begin
		large_ok = (next_addr_q[fres_pkg::LARGE_LOG2-1:0] == '0) &&
			(bytes_left_q >= 25'(fres_pkg::LARGE_BLOCK_BYTES));
		medium_ok = (next_addr_q[fres_pkg::MEDIUM_LOG2-1:0] == '0) &&
			(bytes_left_q >= 25'(fres_pkg::MEDIUM_BLOCK_BYTES));
		if (large_ok) begin
			size = 25'(fres_pkg::LARGE_BLOCK_BYTES);
			erase_cmd = fres_pkg::CMD_LARGE;
		end else if (medium_ok) begin
			size = 25'(fres_pkg::MEDIUM_BLOCK_BYTES);
			erase_cmd = fres_pkg::CMD_MEDIUM;
		end else begin
			size = 25'(fres_pkg::SECTOR_BYTES);
			erase_cmd = fres_pkg::CMD_SECTOR;
		end
		finish = bytes_left_q <= size;
		addr_next = next_addr_q + ADDR_BITS'(size);
		addr_w = 32'(next_addr_q);
	end

	always_comb begin
		job.erase = 1'b0;
		job.status = fres_pkg::ST_OK;
		job.cmd = erase_cmd;
		job.addr = addr_w[23:0];
		if (cmd.opcode == fres_pkg::OP_START) begin
			if (erasing_q || cmd.length == '0) begin
				job.status = fres_pkg::ST_REJECT;
			end
		end else if (!erasing_q || cmd.device_busy) begin
			job.status = fres_pkg::ST_NOTHING;
		end else begin
			job.erase = 1'b1;
			job.status = finish ? fres_pkg::ST_DONE : fres_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erasing_q <= 1'b0;
			next_addr_q <= '0;
			bytes_left_q <= '0;
		end else if (job_push) begin
			if (cmd.opcode == fres_pkg::OP_START) begin
				if (!erasing_q && cmd.length != '0) begin
					erasing_q <= 1'b1;
					next_addr_q <= base_w[ADDR_BITS-1:0];
					bytes_left_q <= rounded[24:0];
				end
			end else if (erasing_q && !cmd.device_busy) begin
				if (finish) begin
					erasing_q <= 1'b0;
					bytes_left_q <= '0;
				end else begin
					next_addr_q <= addr_next;
					bytes_left_q <= bytes_left_q - size;
				end
			end
		end
	end

endmodule

// ----- design/fres_queue.sv -----
module fres_queue #(
	parameter int DEPTH = fres_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  fres_pkg::job_t wdata,
	output logic           full,
	input  logic           rd,
	output fres_pkg::job_t rdata,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fres_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/fres_back.sv -----
module fres_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fres_pkg::job_t      job,
	input  logic                q_empty,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output fres_pkg::out_item_t res
);

	logic [fres_pkg::STEP_W-1:0] step_q;
	fres_pkg::out_item_t         res_q;
	logic                        valid_q;
	fres_pkg::out_item_t         nxt;
	logic                        load;
	logic                        job_last;

	assign load = !valid_q || pop;
	assign job_last = !job.erase || step_q == fres_pkg::STEP_W'(fres_pkg::FRAME_LEN - 1);
	assign q_pop = load && !q_empty && job_last;
	assign empty = !valid_q;
	assign res = res_q;

	// erase frames: ewsr | wrsr 00 | wren | cmd a2 a1 a0
	always_comb begin
		nxt.spi_byte = 8'h00;
		nxt.has_byte = job.erase;
		nxt.frame_end = 1'b0;
		nxt.status = job.status;
		nxt.last = job_last;
		if (job.erase) begin
			case (step_q)
				3'd0: begin
					nxt.spi_byte = fres_pkg::CMD_EWSR;
					nxt.frame_end = 1'b1;
				end
				3'd1: nxt.spi_byte = fres_pkg::CMD_WRSR;
				3'd2: begin
					nxt.spi_byte = fres_pkg::SR_CLEAR;
					nxt.frame_end = 1'b1;
				end
				3'd3: begin
					nxt.spi_byte = fres_pkg::CMD_WREN;
					nxt.frame_end = 1'b1;
				end
				3'd4: nxt.spi_byte = job.cmd;
				3'd5: nxt.spi_byte = job.addr[23:16];
				3'd6: nxt.spi_byte = job.addr[15:8];
				default: begin
					nxt.spi_byte = job.addr[7:0];
					nxt.frame_end = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				step_q <= job_last ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule

// ----- design/flash_range_erase_sequencer_top.sv -----
// result of an item passes through the job queue and the back output register, first byte included
// a start, a reject or an idle or busy tick gives one result
// an erase tick gives eight results, one per cycle from the back output register while each is popped
// a two-entry job queue lets the front take new items while the back is sending
// reset clears erasing, address, byte count, queue pointers and output valid flag at once
module flash_range_erase_sequencer_top #(
	parameter int ADDR_BITS = fres_pkg::ADDR_BITS,
	parameter int QUEUE_DEPTH = fres_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  fres_pkg::in_item_t  cmd,
	input  logic                pop,
	output logic                empty,
	output fres_pkg::out_item_t res
);

	logic           job_push;
	fres_pkg::job_t job_in;
	fres_pkg::job_t job_head;
	logic           q_empty;
	logic           q_pop;

	fres_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd      (cmd),
		.q_full   (full),
		.job_push (job_push),
		.job      (job_in)
	);

	fres_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (full),
		.rd     (q_pop),
		.rdata  (job_head),
		.empty  (q_empty)
	);

	fres_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (job_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

endmodule

// ----- design/fres_checker.sv -----
module fres_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pop,
	input logic                empty,
	input fres_pkg::out_item_t res
);

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while waiting");

	a_fend: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.frame_end |-> res.has_byte)
		else $error("frame end without byte");

	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.has_byte |-> res.last && res.spi_byte == 8'h00)
		else $error("byteless result not alone or not zero");

	a_bytestat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.has_byte |->
		res.status == fres_pkg::ST_OK || res.status == fres_pkg::ST_DONE)
		else $error("byte with reject or idle status");

	// the last erase byte closes its frame
	a_lastframe: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.has_byte && res.last |-> res.frame_end)
		else $error("last byte does not close frame");

endmodule

bind flash_range_erase_sequencer_top fres_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.res    (res)
);

// ----- sim/flash_range_erase_sequencer_top_tb.sv -----
module flash_range_erase_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fres_pkg::*;

	localparam int PERIOD = 8;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 90;

	typedef struct {
		opcode_t     op;
		logic [23:0] addr;
		logic [24:0] len;
		logic        busy;
		bit          typed;
		status_t     st;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	in_item_t cmd = '0;
	out_item_t res;

	// predicted sequencer state
	logic        erasing_q = 1'b0;
	logic [23:0] erase_addr = '0;
	logic [24:0] erase_left = '0;

	out_item_t results_due[$];
	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	dir_row_t dir_rows [19] = '{
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b1, ST_NOTHING},
		'{OP_TICK,  24'hFFFFFF, 25'h1FFFFFF, 1'b1, 1'b1, ST_NOTHING},
		'{OP_START, 24'h000000, 25'h0000000, 1'b0, 1'b1, ST_REJECT},
		'{OP_START, 24'hFFFFFF, 25'h0000002, 1'b1, 1'b1, ST_OK},
		'{OP_START, 24'h000000, 25'h1FFFFFF, 1'b0, 1'b1, ST_REJECT},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b1, 1'b1, ST_NOTHING},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_START, 24'hFF8000, 25'h0010000, 1'b0, 1'b1, ST_REJECT},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_START, 24'h010000, 25'h0018000, 1'b0, 1'b1, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b1, 1'b1, ST_NOTHING},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_START, 24'h007800, 25'h0001000, 1'b0, 1'b1, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b0, ST_OK},
		'{OP_TICK,  24'h000000, 25'h0000000, 1'b0, 1'b1, ST_NOTHING},
		'{OP_START, 24'hFFFFFF, 25'h0000001, 1'b1, 1'b1, ST_OK}
	};

	flash_range_erase_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.pop(pop),
		.empty(empty),
		.res(res)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic void erase_step(input in_item_t it);
		logic [24:0] len;
		logic [23:0] base;
		logic [25:0] span;
		logic [23:0] a;
		logic [24:0] blk;
		logic [7:0]  op_byte;
		status_t     st;
		if (it.opcode == OP_START) begin
			if (erasing_q || it.length == '0) begin
				results_due.push_back('{8'h00, 1'b0, 1'b0, ST_REJECT, 1'b1});
			end else begin
				len = (it.length > LEN_MAX) ? LEN_MAX : it.length;
				base = it.start_addr & ~24'(SECTOR_BYTES - 1);
				// round the covered span up to whole sectors
				span = 26'(len) + 26'(it.start_addr - base) - 26'd1;
				span = (span & ~26'(SECTOR_BYTES - 1)) + 26'(SECTOR_BYTES);
				erasing_q = 1'b1;
				erase_addr = base;
				erase_left = span[24:0];
				results_due.push_back('{8'h00, 1'b0, 1'b0, ST_OK, 1'b1});
			end
		end else if (!erasing_q || it.device_busy) begin
			results_due.push_back('{8'h00, 1'b0, 1'b0, ST_NOTHING, 1'b1});
		end else begin
			a = erase_addr;
			if (a[LARGE_LOG2-1:0] == '0 && erase_left >= 25'(LARGE_BLOCK_BYTES)) begin
				op_byte = CMD_LARGE;
				blk = 25'(LARGE_BLOCK_BYTES);
			end else if (a[MEDIUM_LOG2-1:0] == '0 && erase_left >= 25'(MEDIUM_BLOCK_BYTES)) begin
				op_byte = CMD_MEDIUM;
				blk = 25'(MEDIUM_BLOCK_BYTES);
			end else begin
				op_byte = CMD_SECTOR;
				blk = 25'(SECTOR_BYTES);
			end
			if (erase_left <= blk) begin
				erase_left = '0;
				erasing_q = 1'b0;
				st = ST_DONE;
			end else begin
				erase_addr = a + blk[23:0];
				erase_left = erase_left - blk;
				st = ST_OK;
			end
			results_due.push_back('{CMD_EWSR, 1'b1, 1'b1, st, 1'b0});
			results_due.push_back('{CMD_WRSR, 1'b1, 1'b0, st, 1'b0});
			results_due.push_back('{SR_CLEAR, 1'b1, 1'b1, st, 1'b0});
			results_due.push_back('{CMD_WREN, 1'b1, 1'b1, st, 1'b0});
			results_due.push_back('{op_byte, 1'b1, 1'b0, st, 1'b0});
			results_due.push_back('{a[23:16], 1'b1, 1'b0, st, 1'b0});
			results_due.push_back('{a[15:8], 1'b1, 1'b0, st, 1'b0});
			results_due.push_back('{a[7:0], 1'b1, 1'b1, st, 1'b1});
		end
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input status_t st);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (full);
		erase_step(it);
		// rows with a hand-written answer replace the predicted one
		if (typed) begin
			void'(results_due.pop_back());
			results_due.push_back('{8'h00, 1'b0, 1'b0, st, 1'b1});
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (pop && !empty) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (res.spi_byte !== want.spi_byte) begin
					$display("%0t: spi_byte expected %h got %h", $time, want.spi_byte,
						res.spi_byte);
					mismatches++;
				end
				if (res.has_byte !== want.has_byte) begin
					$display("%0t: has_byte expected %b got %b", $time, want.has_byte,
						res.has_byte);
					mismatches++;
				end
				if (res.frame_end !== want.frame_end) begin
					$display("%0t: frame_end expected %b got %b", $time, want.frame_end,
						res.frame_end);
					mismatches++;
				end
				if (res.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						res.status);
					mismatches++;
				end
				if (res.last !== want.last) begin
					$display("%0t: last expected %b got %b", $time, want.last, res.last);
					mismatches++;
				end
			end
		end
		pop <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// ends the run if neither side moves an item for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		in_item_t    it;
		logic [23:0] addr;
		logic [24:0] len;
		int          sent;
		int          r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 38;
		rx_idle_pct = 60;
		foreach (dir_rows[i]) begin
			it = '{dir_rows[i].op, dir_rows[i].addr, dir_rows[i].len, dir_rows[i].busy};
			send_item(it, dir_rows[i].typed, dir_rows[i].st);
		end
		// tick until the range from the last row is finished
		while (erasing_q) begin
			it = '{OP_TICK, 24'($urandom), 25'($urandom), 1'($urandom_range(99) < 25)};
			send_item(it, 1'b0, ST_OK);
		end

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 60 : 0;
			rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 38 : 0;
			sent = 0;
			while (sent < PHASE_ITEMS || erasing_q) begin
				r = $urandom_range(99);
				if (erasing_q) begin
					if (r < 8)
						it = '{OP_START, 24'($urandom), 25'($urandom), 1'($urandom)};
					else
						it = '{OP_TICK, 24'($urandom), 25'($urandom),
							1'($urandom_range(99) < 20)};
				end else if (r < 10) begin
					it = '{OP_TICK, 24'($urandom), 25'($urandom), 1'($urandom)};
				end else if (r < 16) begin
					it = '{OP_START, 24'($urandom), 25'h0, 1'($urandom)};
				end else begin
					addr = 24'($urandom);
					if ($urandom_range(3) == 0)
						addr[15:0] = '0;
					else if ($urandom_range(3) == 0)
						addr[11:0] = '0;
					r = $urandom_range(99);
					if (r < 65)
						len = 25'($urandom_range(1, 32'h20000));
					else if (r < 98)
						len = 25'($urandom_range(1, 32'h100000));
					else
						len = 25'($urandom_range(32'h100001, 32'h1FFFFFF));
					it = '{OP_START, addr, len, 1'($urandom)};
				end
				send_item(it, 1'b0, ST_OK);
				sent++;
			end
			// hold the sender off until every result is back
			push <= 1'b0;
			@(posedge clk);
			while (results_due.size() != 0) @(posedge clk);
		end

		repeat (16) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/fres_pkg.sv
design/fres_front.sv
design/fres_queue.sv
design/fres_back.sv
design/flash_range_erase_sequencer_top.sv
design/fres_checker.sv
sim/flash_range_erase_sequencer_top_tb.sv
